[design/dfn_pkg.sv]
// ----------------------------------------------------------------------------
// dfn_pkg
// Shared constants and types for the detection filter and NMS block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfn_pkg;

    localparam int MAX_DET_DEFAULT = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [15:0] CONF_THR_RST  = 16'd16384;
    localparam logic [15:0] IOU_THR_RST   = 16'd29491;
    localparam logic [15:0] SCALE_X_RST   = 16'd4096;
    localparam logic [15:0] SCALE_Y_RST   = 16'd4096;

    // register indexes of the configuration port
    localparam logic [1:0] REG_CONF_THR = 2'd0;
    localparam logic [1:0] REG_IOU_THR  = 2'd1;
    localparam logic [1:0] REG_SCALE_X  = 2'd2;
    localparam logic [1:0] REG_SCALE_Y  = 2'd3;

    // classified candidate passed from front to back
    typedef struct packed {
        logic        keep;
        logic        last;
        logic [15:0] score;
        logic [7:0]  cls;
        logic [63:0] box;   // h, w, cy, cx from msb to lsb
    } entry_t;

    // one result on the output channel
    typedef struct packed {
        logic        kept;
        logic [7:0]  cls;
        logic [15:0] score;
        logic [63:0] box;
        logic        ovf;
        logic        fin;
    } result_t;

    function automatic logic [15:0] sat16(input logic [19:0] v);
        sat16 = (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

[design/dfn_front.sv]
// ----------------------------------------------------------------------------
// dfn_front
// Filters candidates by score and area and scales them to center and size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfn_front
    import dfn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] conf_thr,
    input  logic [15:0] scale_x,
    input  logic [15:0] scale_y,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] left,
    input  logic [15:0] top,
    input  logic [15:0] right,
    input  logic [15:0] bottom,
    input  logic [15:0] score,
    input  logic [7:0]  cls,
    input  logic        last,
    output logic        push,
    output entry_t      push_entry,
    input  logic        q_full
);

    logic        st_vld_reg;
    logic        st_keep_reg, st_last_reg;
    logic [15:0] st_score_reg;
    logic [7:0]  st_cls_reg;
    logic [32:0] px_reg, py_reg;
    logic [31:0] pw_reg, ph_reg;
    logic        advance, accept;
    logic [16:0] sum_x, sum_y;
    logic [15:0] dif_x, dif_y;

    assign advance  = st_vld_reg && !q_full;
    assign in_ready = !st_vld_reg || !q_full;
    assign accept   = in_valid && in_ready;

    assign sum_x = {1'b0, left} + {1'b0, right};
    assign sum_y = {1'b0, top} + {1'b0, bottom};
    assign dif_x = right - left;
    assign dif_y = bottom - top;

    // hold the stage valid until the queue has room for it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= 1'b0;
        end else if (accept) begin
            st_vld_reg <= 1'b1;
        end else if (advance) begin
            st_vld_reg <= 1'b0;
        end
    end

    // classify and multiply by the scale
    always_ff @(posedge aclk) begin
        if (accept) begin
            st_keep_reg  <= (score >= conf_thr) && (right > left) && (bottom > top);
            st_last_reg  <= last;
            st_score_reg <= score;
            st_cls_reg   <= cls;
            px_reg       <= sum_x * scale_x;
            py_reg       <= sum_y * scale_y;
            pw_reg       <= dif_x * scale_x;
            ph_reg       <= dif_y * scale_y;
        end
    end

    // shift, saturate and drop rejected non-last items
    assign push = advance && (st_keep_reg || st_last_reg);
    always_comb begin
        push_entry.keep  = st_keep_reg;
        push_entry.last  = st_last_reg;
        push_entry.score = st_score_reg;
        push_entry.cls   = st_cls_reg;
        push_entry.box   = {sat16(ph_reg[31:12]), sat16(pw_reg[31:12]),
                            sat16(py_reg[32:13]), sat16(px_reg[32:13])};
    end

endmodule

[design/dfn_fifo.sv]
// ----------------------------------------------------------------------------
// dfn_fifo
// Short queue of classified candidates between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfn_fifo
    import dfn_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   pop_valid,
    output entry_t pop_entry
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    entry_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [PW:0]     cnt_reg;
    logic            do_pop;

    assign full      = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_entry = slot_reg[rd_reg];
    assign do_pop    = pop && pop_valid;

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + PW'(1);
            if (do_pop) rd_reg <= rd_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= push_entry;
    end

endmodule

[design/dfn_iou.sv]
// ----------------------------------------------------------------------------
// dfn_iou
// Four-stage overlap test: intersection > threshold * union.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfn_iou (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] box_a,
    input  logic [63:0] box_b,
    input  logic [15:0] thr,
    output logic        done,
    output logic        hit
);

    logic [3:0]         vld_reg;
    logic [17:0]        iw_reg, ih_reg;
    logic [15:0]        aw_reg, ah_reg, bw_reg, bh_reg;
    logic [35:0]        inter2_reg, inter3_reg;
    logic [31:0]        pa_reg, pb_reg;
    logic [35:0]        uni_reg;
    logic               hit_reg;
    logic signed [18:0] alx, ahx, aly, ahy, blx, bhx, bly, bhy;
    logic signed [18:0] x1, x2, y1, y2;
    logic [51:0]        lhs, rhs;

    // edges at twice the scale
    assign alx = $signed({2'b0, box_a[15:0], 1'b0}) - $signed({3'b0, box_a[47:32]});
    assign ahx = $signed({2'b0, box_a[15:0], 1'b0}) + $signed({3'b0, box_a[47:32]});
    assign aly = $signed({2'b0, box_a[31:16], 1'b0}) - $signed({3'b0, box_a[63:48]});
    assign ahy = $signed({2'b0, box_a[31:16], 1'b0}) + $signed({3'b0, box_a[63:48]});
    assign blx = $signed({2'b0, box_b[15:0], 1'b0}) - $signed({3'b0, box_b[47:32]});
    assign bhx = $signed({2'b0, box_b[15:0], 1'b0}) + $signed({3'b0, box_b[47:32]});
    assign bly = $signed({2'b0, box_b[31:16], 1'b0}) - $signed({3'b0, box_b[63:48]});
    assign bhy = $signed({2'b0, box_b[31:16], 1'b0}) + $signed({3'b0, box_b[63:48]});
    assign x1 = (alx > blx) ? alx : blx;
    assign x2 = (ahx < bhx) ? ahx : bhx;
    assign y1 = (aly > bly) ? aly : bly;
    assign y2 = (ahy < bhy) ? ahy : bhy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    // stage 1: clamped overlaps
    always_ff @(posedge aclk) begin
        iw_reg <= (x2 > x1) ? 18'(x2 - x1) : '0;
        ih_reg <= (y2 > y1) ? 18'(y2 - y1) : '0;
        aw_reg <= box_a[47:32];
        ah_reg <= box_a[63:48];
        bw_reg <= box_b[47:32];
        bh_reg <= box_b[63:48];
    end

    // stage 2: intersection and areas
    always_ff @(posedge aclk) begin
        inter2_reg <= iw_reg * ih_reg;
        pa_reg     <= aw_reg * ah_reg;
        pb_reg     <= bw_reg * bh_reg;
    end

    // stage 3: union
    always_ff @(posedge aclk) begin
        uni_reg    <= {2'b0, pa_reg, 2'b0} + {2'b0, pb_reg, 2'b0} - inter2_reg;
        inter3_reg <= inter2_reg;
    end

    // stage 4: compare against the threshold
    assign lhs = {inter3_reg, 16'b0};
    assign rhs = thr * uni_reg;
    always_ff @(posedge aclk) begin
        hit_reg <= (uni_reg != '0) && (lhs > rhs);
    end

    assign done = vld_reg[3];
    assign hit  = hit_reg;

endmodule

[design/dfn_back.sv]
// ----------------------------------------------------------------------------
// dfn_back
// Stores kept boxes, then selects by score and suppresses overlaps per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfn_back
    import dfn_pkg::*;
#(
    parameter int MAX_DETECTIONS = MAX_DET_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] iou_thr,
    input  logic        q_valid,
    input  entry_t      q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);

    localparam int AW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int CW = $clog2(MAX_DETECTIONS + 1);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_SEL_RD   = 4'd1;
    localparam logic [3:0] S_SEL_CHK  = 4'd2;
    localparam logic [3:0] S_FETCH    = 4'd3;
    localparam logic [3:0] S_FETCH_W  = 4'd4;
    localparam logic [3:0] S_EMIT     = 4'd5;
    localparam logic [3:0] S_SUP_RD   = 4'd6;
    localparam logic [3:0] S_SUP_CHK  = 4'd7;
    localparam logic [3:0] S_SUP_WAIT = 4'd8;
    localparam logic [3:0] S_FINAL    = 4'd9;

    logic [23:0]               score_mem [MAX_DETECTIONS];
    logic [63:0]               box_mem   [MAX_DETECTIONS];
    logic [23:0]               sdata_reg;
    logic [63:0]               bdata_reg;
    logic [3:0]                state_reg;
    logic [CW-1:0]             cnt_reg, idx_reg;
    logic                      ovf_reg;
    logic [MAX_DETECTIONS-1:0] dead_reg;
    logic                      found_reg;
    logic [AW-1:0]             best_reg;
    logic [15:0]               best_score_reg;
    logic [7:0]                best_cls_reg;
    logic [63:0]               a_box_reg;
    logic                      pend_vld_reg;
    result_t                   pend_reg;
    logic                      out_vld_reg;
    result_t                   out_reg;
    result_t                   fin_res;
    logic [AW-1:0]             rd_addr, idx_a;
    logic                      wr_en, out_free, out_load, iou_start, iou_done, iou_hit;

    assign idx_a    = idx_reg[AW-1:0];
    assign rd_addr  = (state_reg == S_FETCH) ? best_reg : idx_a;
    assign q_pop    = (state_reg == S_LOAD) && q_valid;
    assign wr_en    = q_pop && q_entry.keep && (cnt_reg < CW'(MAX_DETECTIONS));
    assign out_free = !out_vld_reg || out_ready;
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_FINAL)) && out_free;
    assign iou_start = (state_reg == S_SUP_CHK) && !dead_reg[idx_a]
                       && (sdata_reg[23:16] == best_cls_reg);

    // build the closing result of the frame
    always_comb begin
        fin_res     = '0;
        fin_res.ovf = ovf_reg;
        if (pend_vld_reg) fin_res = pend_reg;
        fin_res.fin = 1'b1;
    end

    // store writes and registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            score_mem[cnt_reg[AW-1:0]] <= {q_entry.cls, q_entry.score};
            box_mem[cnt_reg[AW-1:0]]   <= q_entry.box;
        end
        sdata_reg <= score_mem[rd_addr];
        bdata_reg <= box_mem[rd_addr];
    end

    dfn_iou u_iou (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (iou_start),
        .box_a   (a_box_reg),
        .box_b   (bdata_reg),
        .thr     (iou_thr),
        .done    (iou_done),
        .hit     (iou_hit)
    );

    // sequence load, select, suppress and emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            ovf_reg      <= 1'b0;
            dead_reg     <= '0;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (out_vld_reg && out_ready && !out_load) out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD: begin
                    if (q_pop) begin
                        if (wr_en) cnt_reg <= cnt_reg + CW'(1);
                        else if (q_entry.keep) ovf_reg <= 1'b1;
                        if (q_entry.last) begin
                            idx_reg   <= '0;
                            found_reg <= 1'b0;
                            state_reg <= S_SEL_RD;
                        end
                    end
                end
                S_SEL_RD: begin
                    if (idx_reg == cnt_reg) begin
                        if (found_reg) begin
                            dead_reg[best_reg] <= 1'b1;
                            state_reg <= S_FETCH;
                        end else begin
                            state_reg <= S_FINAL;
                        end
                    end else begin
                        state_reg <= S_SEL_CHK;
                    end
                end
                S_SEL_CHK: begin
                    // strict compare keeps the earlier entry on a tie
                    if (!dead_reg[idx_a] &&
                        (!found_reg || sdata_reg[15:0] > best_score_reg)) begin
                        found_reg      <= 1'b1;
                        best_reg       <= idx_a;
                        best_score_reg <= sdata_reg[15:0];
                        best_cls_reg   <= sdata_reg[23:16];
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_SEL_RD;
                end
                S_FETCH: begin
                    state_reg <= S_FETCH_W;
                end
                S_FETCH_W: begin
                    a_box_reg <= bdata_reg;
                    idx_reg   <= '0;
                    if (pend_vld_reg) begin
                        state_reg <= S_EMIT;
                    end else begin
                        pend_vld_reg   <= 1'b1;
                        pend_reg.kept  <= 1'b1;
                        pend_reg.cls   <= best_cls_reg;
                        pend_reg.score <= best_score_reg;
                        pend_reg.box   <= bdata_reg;
                        pend_reg.ovf   <= ovf_reg;
                        pend_reg.fin   <= 1'b0;
                        state_reg      <= S_SUP_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_vld_reg    <= 1'b1;
                        out_reg        <= pend_reg;
                        pend_reg.cls   <= best_cls_reg;
                        pend_reg.score <= best_score_reg;
                        pend_reg.box   <= a_box_reg;
                        state_reg      <= S_SUP_RD;
                    end
                end
                S_SUP_RD: begin
                    if (idx_reg == cnt_reg) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SEL_RD;
                    end else begin
                        state_reg <= S_SUP_CHK;
                    end
                end
                S_SUP_CHK: begin
                    if (iou_start) begin
                        state_reg <= S_SUP_WAIT;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SUP_RD;
                    end
                end
                S_SUP_WAIT: begin
                    if (iou_done) begin
                        if (iou_hit) dead_reg[idx_a] <= 1'b1;
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SUP_RD;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        out_vld_reg  <= 1'b1;
                        out_reg      <= fin_res;
                        cnt_reg      <= '0;
                        ovf_reg      <= 1'b0;
                        dead_reg     <= '0;
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_DETECTIONS))
        else $error("entry count above capacity");
    a_iou_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        iou_done |-> state_reg == S_SUP_WAIT)
        else $error("overlap result outside suppression wait");
    a_best_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FETCH |-> dead_reg[best_reg])
        else $error("selected entry not retired");

endmodule

[design/detection_filter_and_nms.sv]
// ----------------------------------------------------------------------------
// detection_filter_and_nms
// Score/area filter, scaling and class-aware greedy NMS over one frame.
// ----------------------------------------------------------------------------
// Loading: one candidate per cycle unless the queue is full; a kept candidate
// passes the front stage registers and the queue before it is written to the
// store. After the last candidate, each survivor is found by a scan of the n
// stored entries, fetched and emitted; suppression runs each live same-class
// entry through the four-stage overlap unit and skips every other entry.
// Synchronous reset clears queue, counts, flags and registers, not the stores.
`timescale 1ns / 1ps

module detection_filter_and_nms
    import dfn_pkg::*;
#(
    parameter int MAX_DETECTIONS = MAX_DET_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_box_left,
    input  logic [15:0] s_box_top,
    input  logic [15:0] s_box_right,
    input  logic [15:0] s_box_bottom,
    input  logic [15:0] s_score,
    input  logic [7:0]  s_class_code,
    input  logic        s_last_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kept_valid,
    output logic [7:0]  m_out_class,
    output logic [15:0] m_out_score,
    output logic [15:0] m_center_x,
    output logic [15:0] m_center_y,
    output logic [15:0] m_box_width,
    output logic [15:0] m_box_height,
    output logic        m_overflow,
    output logic        m_final_item
);

    logic [15:0] conf_thr_reg, iou_thr_reg, scale_x_reg, scale_y_reg;
    logic        push, q_full, q_valid, q_pop;
    entry_t      push_entry, q_entry;
    result_t     res;

    assign pready = 1'b1;

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conf_thr_reg <= CONF_THR_RST;
            iou_thr_reg  <= IOU_THR_RST;
            scale_x_reg  <= SCALE_X_RST;
            scale_y_reg  <= SCALE_Y_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_CONF_THR: conf_thr_reg <= pwdata[15:0];
                REG_IOU_THR:  iou_thr_reg  <= pwdata[15:0];
                REG_SCALE_X:  scale_x_reg  <= pwdata[15:0];
                REG_SCALE_Y:  scale_y_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back configuration registers
    always_comb begin
        unique case (paddr[3:2])
            REG_CONF_THR: prdata = {16'b0, conf_thr_reg};
            REG_IOU_THR:  prdata = {16'b0, iou_thr_reg};
            REG_SCALE_X:  prdata = {16'b0, scale_x_reg};
            REG_SCALE_Y:  prdata = {16'b0, scale_y_reg};
            default:      prdata = '0;
        endcase
    end

    dfn_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .conf_thr   (conf_thr_reg),
        .scale_x    (scale_x_reg),
        .scale_y    (scale_y_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .left       (s_box_left),
        .top        (s_box_top),
        .right      (s_box_right),
        .bottom     (s_box_bottom),
        .score      (s_score),
        .cls        (s_class_code),
        .last       (s_last_item),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    dfn_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    dfn_back #(
        .MAX_DETECTIONS (MAX_DETECTIONS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iou_thr   (iou_thr_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res)
    );

    assign m_kept_valid = res.kept;
    assign m_out_class  = res.cls;
    assign m_out_score  = res.score;
    assign m_center_x   = res.box[15:0];
    assign m_center_y   = res.box[31:16];
    assign m_box_width  = res.box[47:32];
    assign m_box_height = res.box[63:48];
    assign m_overflow   = res.ovf;
    assign m_final_item = res.fin;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives candidate frames into the detection filter and NMS block, predicts
// the surviving boxes per frame and checks every result field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import dfn_pkg::*;
();

    localparam int MAX_DET = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [7:0]  cls;
        logic        last;
    } cand_t;

    typedef struct packed {
        logic        kept;
        logic [7:0]  cls;
        logic [15:0] score;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic        ovf;
        logic        fin;
    } survivor_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cand_t       s_cur = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kept_valid, m_overflow, m_final_item;
    logic [7:0]  m_out_class;
    logic [15:0] m_out_score, m_center_x, m_center_y, m_box_width, m_box_height;

    detection_filter_and_nms dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_box_left(s_cur.left), .s_box_top(s_cur.top), .s_box_right(s_cur.right),
        .s_box_bottom(s_cur.bottom), .s_score(s_cur.score),
        .s_class_code(s_cur.cls), .s_last_item(s_cur.last),
        .m_valid(m_valid), .m_ready(m_ready), .m_kept_valid(m_kept_valid),
        .m_out_class(m_out_class), .m_out_score(m_out_score),
        .m_center_x(m_center_x), .m_center_y(m_center_y),
        .m_box_width(m_box_width), .m_box_height(m_box_height),
        .m_overflow(m_overflow), .m_final_item(m_final_item)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] conf_thr = CONF_THR_RST, iou_thr = IOU_THR_RST;
    logic [15:0] scl_x = SCALE_X_RST, scl_y = SCALE_Y_RST;
    logic [63:0] frame_box [MAX_DET];
    logic [23:0] frame_score [MAX_DET];
    int          frame_count = 0;
    logic        frame_ovf = 1'b0;

    cand_t       pending_cands [$];
    survivor_t   expected_survivors [$];
    int          errors = 0;
    bit          no_idle = 1'b0;
    bit          rx_hold = 1'b0;
    bit          tx_pause = 1'b0;
    bit          in_acc = 1'b0;
    longint      cycles = 0;

    function automatic logic [15:0] clip16(input logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic bit too_close(input logic [63:0] a, input logic [63:0] b);
        longint ax, ay, aw, ah, bx, by, bw, bh, x1, y1, x2, y2, iw, ih, inter, uni;
        ax = a[15:0]; ay = a[31:16]; aw = a[47:32]; ah = a[63:48];
        bx = b[15:0]; by = b[31:16]; bw = b[47:32]; bh = b[63:48];
        x1 = (2*ax - aw > 2*bx - bw) ? 2*ax - aw : 2*bx - bw;
        y1 = (2*ay - ah > 2*by - bh) ? 2*ay - ah : 2*by - bh;
        x2 = (2*ax + aw < 2*bx + bw) ? 2*ax + aw : 2*bx + bw;
        y2 = (2*ay + ah < 2*by + bh) ? 2*ay + ah : 2*by + bh;
        iw = (x2 > x1) ? x2 - x1 : 0;
        ih = (y2 > y1) ? y2 - y1 : 0;
        inter = iw * ih;
        uni = 4*aw*ah + 4*bw*bh - inter;
        if (uni <= 0) return 1'b0;
        return (longint'(unsigned'(inter)) * 65536) > (longint'(iou_thr) * uni);
    endfunction

    // append one candidate to the pending requests
    task automatic add_cand(input cand_t c);
        pending_cands = {pending_cands, c};
    endtask

    // filter, scale and store one candidate; run NMS at frame end
    task automatic predict_candidate(input cand_t c);
        int order [MAX_DET];
        bit supp [MAX_DET];
        int n, key, j, found;
        logic [63:0] cx, cy, w, h;
        survivor_t r;
        if (c.score >= conf_thr && c.right > c.left && c.bottom > c.top) begin
            if (frame_count < MAX_DET) begin
                cx = ((64'(c.left) + c.right) * scl_x) >> 13;
                cy = ((64'(c.top) + c.bottom) * scl_y) >> 13;
                w  = (64'(c.right - c.left) * scl_x) >> 12;
                h  = (64'(c.bottom - c.top) * scl_y) >> 12;
                frame_box[frame_count] = {clip16(h), clip16(w), clip16(cy), clip16(cx)};
                frame_score[frame_count] = {c.cls, c.score};
                frame_count++;
            end else begin
                frame_ovf = 1'b1;
            end
        end
        if (!c.last) return;
        n = frame_count;
        for (int i = 0; i < n; i++) begin
            key = i;
            j = i;
            while (j > 0 && frame_score[order[j-1]][15:0] < frame_score[key][15:0]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
            supp[i] = 1'b0;
        end
        found = 0;
        for (int i = 0; i < n; i++) begin
            if (supp[order[i]]) continue;
            for (int k = i + 1; k < n; k++) begin
                if (supp[order[k]]) continue;
                if (frame_score[order[i]][23:16] != frame_score[order[k]][23:16]) continue;
                if (too_close(frame_box[order[i]], frame_box[order[k]]))
                    supp[order[k]] = 1'b1;
            end
            r.kept = 1'b1;
            r.cls = frame_score[order[i]][23:16];
            r.score = frame_score[order[i]][15:0];
            {r.h, r.w, r.cy, r.cx} = frame_box[order[i]];
            r.ovf = frame_ovf;
            r.fin = 1'b0;
            expected_survivors = {expected_survivors, r};
            found++;
        end
        if (found == 0) begin
            r = '0;
            r.ovf = frame_ovf;
            expected_survivors = {expected_survivors, r};
        end
        expected_survivors[$].fin = 1'b1;
        frame_count = 0;
        frame_ovf = 1'b0;
    endtask

    // write one register over the config port and check the readback
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (pready !== 1'b1) begin
            $error("pready exp 1 got %0d", pready);
            errors++;
        end
        if (prdata !== {16'd0, val}) begin
            $error("prdata exp %0d got %0d", val, prdata);
            errors++;
        end
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CONF_THR: conf_thr = val;
            REG_IOU_THR:  iou_thr = val;
            REG_SCALE_X:  scl_x = val;
            default:      scl_y = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cands.size() != 0 || s_valid || expected_survivors.size() != 0)
            @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    function automatic cand_t rand_box(input int span);
        cand_t c;
        c.left = 16'($urandom_range(0, 2000));
        c.top = 16'($urandom_range(0, 2000));
        c.right = 16'(c.left + $urandom_range(0, span));
        c.bottom = 16'(c.top + $urandom_range(0, span));
        c.score = 16'($urandom);
        c.cls = 8'($urandom_range(0, 3));
        c.last = 1'b0;
        return c;
    endfunction

    // queue a frame; mostly clustered boxes so suppression triggers
    task automatic queue_frame(input int len);
        cand_t c, base;
        base = rand_box(400);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    c.left = 16'($urandom); c.top = 16'($urandom);
                    c.right = 16'($urandom); c.bottom = 16'($urandom);
                    c.score = 16'($urandom); c.cls = 8'($urandom);
                end
                1, 2: c = rand_box(3000);
                default: begin
                    c = base;
                    c.left = 16'(base.left + $urandom_range(0, 40));
                    c.top = 16'(base.top + $urandom_range(0, 40));
                    c.right = 16'(base.right + $urandom_range(0, 40));
                    c.bottom = 16'(base.bottom + $urandom_range(0, 40));
                    c.score = 16'($urandom);
                    c.cls = 8'($urandom_range(0, 1));
                end
            endcase
            c.last = (i == len - 1);
            add_cand(c);
        end
    endtask

    // request driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_acc) begin
                predict_candidate(s_cur);
            end
            if (!s_valid || in_acc) begin
                if (pending_cands.size() != 0 && !tx_pause
                        && (no_idle || $urandom_range(0, 99) >= 6)) begin
                    s_cur <= pending_cands.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 6);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        survivor_t e;
        cycles <= cycles + 1;
        in_acc <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_survivors.size() == 0) begin
                $error("unexpected result");
                errors = errors + 1;
            end else begin
                e = expected_survivors.pop_front();
                if (m_kept_valid !== e.kept) begin
                    $error("kept_valid exp %0d got %0d", e.kept, m_kept_valid);
                    errors = errors + 1;
                end
                if (m_out_class !== e.cls) begin
                    $error("out_class exp %0d got %0d", e.cls, m_out_class);
                    errors = errors + 1;
                end
                if (m_out_score !== e.score) begin
                    $error("out_score exp %0d got %0d", e.score, m_out_score);
                    errors = errors + 1;
                end
                if (m_center_x !== e.cx) begin
                    $error("center_x exp %0d got %0d", e.cx, m_center_x);
                    errors = errors + 1;
                end
                if (m_center_y !== e.cy) begin
                    $error("center_y exp %0d got %0d", e.cy, m_center_y);
                    errors = errors + 1;
                end
                if (m_box_width !== e.w) begin
                    $error("box_width exp %0d got %0d", e.w, m_box_width);
                    errors = errors + 1;
                end
                if (m_box_height !== e.h) begin
                    $error("box_height exp %0d got %0d", e.h, m_box_height);
                    errors = errors + 1;
                end
                if (m_overflow !== e.ovf) begin
                    $error("overflow exp %0d got %0d", e.ovf, m_overflow);
                    errors = errors + 1;
                end
                if (m_final_item !== e.fin) begin
                    $error("final_item exp %0d got %0d", e.fin, m_final_item);
                    errors = errors + 1;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        cand_t c;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero area, low score, ties, empty frame
        write_reg(REG_CONF_THR, 16'd0);
        c = '0; c.right = 16'hFFFF; c.bottom = 16'hFFFF; c.score = 16'hFFFF;
        c.cls = 8'hFF; add_cand(c);
        c = '0; c.left = 16'd100; c.right = 16'd100; c.bottom = 16'd50;
        add_cand(c);
        c = '0; c.left = 16'd10; c.top = 16'd10; c.right = 16'd200; c.bottom = 16'd200;
        c.score = 16'd500; c.cls = 8'd3; add_cand(c);
        c.left = 16'd12; add_cand(c);
        c.cls = 8'd4; add_cand(c);
        c.left = 16'hFFFE; c.top = 16'hFFF0; c.right = 16'hFFFF; c.bottom = 16'hFFFF;
        c.score = 16'd0; c.last = 1'b1; add_cand(c);
        wait_drained();
        // empty frame: everything below threshold
        write_reg(REG_CONF_THR, 16'hFFFF);
        c = rand_box(100); c.score = 16'hFFFE; c.last = 1'b1;
        add_cand(c);
        wait_drained();
        // saturation and zero scale, overflow of the store
        write_reg(REG_CONF_THR, 16'd0);
        write_reg(REG_SCALE_X, 16'hFFFF);
        write_reg(REG_SCALE_Y, 16'd0);
        write_reg(REG_IOU_THR, 16'd0);
        for (int i = 0; i < 66; i++) begin
            c = rand_box(3000); c.last = (i == 65);
            add_cand(c);
        end
        no_idle = 1'b1;
        wait_drained();
        no_idle = 1'b0;
        write_reg(REG_IOU_THR, 16'hFFFF);
        write_reg(REG_SCALE_Y, 16'hFFFF);
        queue_frame(8);
        wait_drained();

        // random frames over several settings; hold off the receiver once
        for (int f = 0; f < 24; f++) begin
            write_reg(REG_CONF_THR, 16'($urandom_range(0, 40000)));
            write_reg(REG_IOU_THR, 16'($urandom));
            write_reg(REG_SCALE_X, 16'($urandom_range(1000, 9000)));
            write_reg(REG_SCALE_Y, 16'($urandom_range(1000, 9000)));
            no_idle = (f >= 8 && f < 12);
            if (f == 5) begin
                rx_hold = 1'b1;
                queue_frame(3); queue_frame(3); queue_frame(3); queue_frame(3);
                repeat (400) @(negedge aclk);
                rx_hold = 1'b0;
            end else if (f == 10) begin
                // pause the sender after one frame until every result is back
                queue_frame(5);
                queue_frame(4);
                while (pending_cands.size() > 4) @(negedge aclk);
                tx_pause = 1'b1;
                while (s_valid || expected_survivors.size() != 0) @(negedge aclk);
                tx_pause = 1'b0;
            end else begin
                queue_frame($urandom_range(1, 10));
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[files.f]
design/dfn_pkg.sv
design/dfn_front.sv
design/dfn_fifo.sv
design/dfn_iou.sv
design/dfn_back.sv
design/detection_filter_and_nms.sv
dv/testbench.sv
